>>> rtl/core/jsu_pkg.sv
// Shared types and character constants for the JSON string unescaper.
// Used by the front decoder, the job queue, the byte emitter and the top level.
`default_nettype none

package jsu_pkg;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_ESCAPE = 2'd1,
        PH_HEX    = 2'd2,
        PH_HALT   = 2'd3
    } phase_t;

    // One decoded input item: up to three result bytes, emitted bytes[0] first
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count_m1;   // number of results minus one
        logic            has_data;   // zero for a bare end marker
        logic            str_last;   // item closes the string
    } job_t;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CHAR_B      = 8'h62;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CTRL_BS     = 8'h08;
    localparam logic [7:0] CTRL_FF     = 8'h0C;
    localparam logic [7:0] CTRL_LF     = 8'h0A;
    localparam logic [7:0] CTRL_CR     = 8'h0D;
    localparam logic [7:0] CTRL_TAB    = 8'h09;

    localparam logic [7:0] UTF8_LEAD2  = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3  = 8'hE0;
    localparam logic [7:0] UTF8_CONT   = 8'h80;

endpackage

`default_nettype wire

>>> rtl/core/jsu_front.sv
// Front decoder: escape state machine, hex gathering and UTF-8 encoding.
// Turns an accepted byte into at most one queue job. Depends on jsu_pkg.
`default_nettype none

module jsu_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         accept,
    input  wire logic [7:0]   in_byte,
    input  wire logic         last_byte,
    output jsu_pkg::job_t     job,
    output logic              job_push
);

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      digits_reg, digits_next;
    logic [11:0]     accum_reg, accum_next;

    logic            hex_ok;
    logic [3:0]      hex_val;
    logic [7:0]      esc_byte;
    logic [15:0]     cp;
    logic [1:0]      emit_cnt;
    logic [2:0][7:0] emit_bytes;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            hex_val = in_byte[3:0];
        end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
            hex_val = in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        unique case (in_byte)
            jsu_pkg::CHAR_B: esc_byte = jsu_pkg::CTRL_BS;
            jsu_pkg::CHAR_F: esc_byte = jsu_pkg::CTRL_FF;
            jsu_pkg::CHAR_N: esc_byte = jsu_pkg::CTRL_LF;
            jsu_pkg::CHAR_R: esc_byte = jsu_pkg::CTRL_CR;
            jsu_pkg::CHAR_T: esc_byte = jsu_pkg::CTRL_TAB;
            default:         esc_byte = in_byte;
        endcase
    end

    assign cp = {accum_reg, hex_val};

    // Next state
    always_comb begin
        phase_next  = phase_reg;
        digits_next = digits_reg;
        accum_next  = accum_reg;
        unique case (phase_reg)
            jsu_pkg::PH_NORMAL: begin
                if (in_byte == jsu_pkg::CHAR_BSLASH && !last_byte) begin
                    phase_next = jsu_pkg::PH_ESCAPE;
                end
            end
            jsu_pkg::PH_ESCAPE: begin
                if (in_byte == jsu_pkg::CHAR_U) begin
                    phase_next  = jsu_pkg::PH_HEX;
                    digits_next = 2'd0;
                    accum_next  = 12'd0;
                end else begin
                    phase_next = jsu_pkg::PH_NORMAL;
                end
            end
            jsu_pkg::PH_HEX: begin
                if (!hex_ok) begin
                    phase_next = jsu_pkg::PH_HALT;
                end else if (digits_reg == 2'd3) begin
                    phase_next  = jsu_pkg::PH_NORMAL;
                    digits_next = 2'd0;
                    accum_next  = 12'd0;
                end else begin
                    accum_next  = {accum_reg[7:0], hex_val};
                    digits_next = digits_reg + 2'd1;
                end
            end
            jsu_pkg::PH_HALT: begin
                phase_next = jsu_pkg::PH_HALT;
            end
            default: begin
                phase_next = jsu_pkg::PH_NORMAL;
            end
        endcase
        // end of string returns to the idle state
        if (last_byte) begin
            phase_next  = jsu_pkg::PH_NORMAL;
            digits_next = 2'd0;
            accum_next  = 12'd0;
        end
    end

    // Outputs
    always_comb begin
        emit_cnt   = 2'd0;
        emit_bytes = '0;
        unique case (phase_reg)
            jsu_pkg::PH_NORMAL: begin
                if (!(in_byte == jsu_pkg::CHAR_BSLASH && !last_byte)) begin
                    emit_cnt      = 2'd1;
                    emit_bytes[0] = in_byte;
                end
            end
            jsu_pkg::PH_ESCAPE: begin
                if (in_byte != jsu_pkg::CHAR_U) begin
                    emit_cnt      = 2'd1;
                    emit_bytes[0] = esc_byte;
                end
            end
            jsu_pkg::PH_HEX: begin
                if (hex_ok && digits_reg == 2'd3) begin
                    if (cp[15:7] == 9'd0) begin
                        emit_cnt      = 2'd1;
                        emit_bytes[0] = cp[7:0];
                    end else if (cp[15:11] == 5'd0) begin
                        emit_cnt      = 2'd2;
                        emit_bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'd0, cp[10:6]};
                        emit_bytes[1] = jsu_pkg::UTF8_CONT | {2'd0, cp[5:0]};
                    end else begin
                        emit_cnt      = 2'd3;
                        emit_bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'd0, cp[15:12]};
                        emit_bytes[1] = jsu_pkg::UTF8_CONT | {2'd0, cp[11:6]};
                        emit_bytes[2] = jsu_pkg::UTF8_CONT | {2'd0, cp[5:0]};
                    end
                end
            end
            default: begin
                emit_cnt = 2'd0;
            end
        endcase
    end

    always_comb begin
        job.bytes    = emit_bytes;
        job.has_data = (emit_cnt != 2'd0);
        job.count_m1 = (emit_cnt == 2'd0) ? 2'd0 : emit_cnt - 2'd1;
        job.str_last = last_byte;
        job_push     = accept && ((emit_cnt != 2'd0) || last_byte);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= jsu_pkg::PH_NORMAL;
            digits_reg <= 2'd0;
            accum_reg  <= 12'd0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            digits_reg <= digits_next;
            accum_reg  <= accum_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/jsu_queue.sv
// Short job queue between the decoder and the byte emitter.
// Register file with head and tail pointers. Depends on jsu_pkg.
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  jsu_pkg::job_t      push_job,
    output logic               full,
    input  wire logic          pop,
    output jsu_pkg::job_t      head,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::job_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/jsu_emit.sv
// Byte emitter: walks the bytes of the head job into the output register.
// Pops the job with its final byte. Depends on jsu_pkg.
`default_nettype none

module jsu_emit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  jsu_pkg::job_t    head,
    input  wire logic        head_valid,
    output logic             pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_byte,
    output logic             m_byte_valid,
    output logic             m_run_last,
    output logic             m_string_end
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       bv_reg, rl_reg, se_reg;

    logic       load;
    logic       is_final;
    logic [7:0] sel_byte;

    always_comb begin
        unique case (idx_reg)
            2'd0:    sel_byte = head.bytes[0];
            2'd1:    sel_byte = head.bytes[1];
            2'd2:    sel_byte = head.bytes[2];
            default: sel_byte = 8'd0;
        endcase
    end

    assign load     = head_valid && (!valid_reg || m_ready);
    assign is_final = (idx_reg == head.count_m1);
    assign pop      = load && is_final;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= is_final ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= sel_byte;
            bv_reg   <= head.has_data;
            rl_reg   <= is_final;
            se_reg   <= is_final && head.str_last;
        end
    end

    assign m_valid      = valid_reg;
    assign m_byte       = byte_reg;
    assign m_byte_valid = bv_reg;
    assign m_run_last   = rl_reg;
    assign m_string_end = se_reg;

endmodule

`default_nettype wire

>>> rtl/core/json_string_unescape.sv
// JSON string body unescaper, top level: decoder, job queue, byte emitter.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_emit.
//
//   channel  dir  tdata                          tuser         tlast
//   s_axis   in   [7:0] in_byte                  -             last_byte
//   m_axis   out  [7:0] out_byte, [8] run_last   [0] byte_valid string_end
//
// An input byte is taken every cycle while the job queue has room; a \u
// escape that expands to two or three bytes holds the emitter, one result
// byte per cycle while m_axis_tready is high. Back-pressure on m_axis fills
// the QUEUE_DEPTH-entry queue, then drops s_axis_tready. Reset returns the
// decoder to the pass-through phase.
`default_nettype none

module json_string_unescape #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [8] run_last
    output logic [0:0]       m_axis_tuser,   // [0] byte_valid
    output logic             m_axis_tlast
);

    jsu_pkg::job_t front_job, head_job;
    logic          job_push, q_full, q_empty, q_pop, accept;
    logic [7:0]    out_byte;
    logic          byte_valid, run_last, string_end;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    jsu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_byte   (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .job       (front_job),
        .job_push  (job_push)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (front_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_job),
        .empty    (q_empty)
    );

    jsu_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head_job),
        .head_valid   (!q_empty),
        .pop          (q_pop),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_byte       (out_byte),
        .m_byte_valid (byte_valid),
        .m_run_last   (run_last),
        .m_string_end (string_end)
    );

    assign m_axis_tdata = {7'd0, run_last, out_byte};
    assign m_axis_tuser = byte_valid;
    assign m_axis_tlast = string_end;

    // end of string always closes a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[8])
        else $error("string end without run end");

    // a result with no data is only the bare end marker
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tlast && m_axis_tdata[8] && (m_axis_tdata[7:0] == 8'd0))
        else $error("empty result that is not an end marker");

    // the queue never takes a job while full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(job_push && q_full))
        else $error("push into full queue");

    // a pop only happens when a job waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
